// File: rtl/gf_zech_log_alu_macros.svh
// assertion macros for the zech log alu
`ifndef GF_ZECH_LOG_ALU_MACROS_SVH
`define GF_ZECH_LOG_ALU_MACROS_SVH

// property checked at every edge outside reset
`define GZLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal holds in the cycle after the condition
`define GZLA_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// File: rtl/gzla_pkg.sv
package gzla_pkg;

  localparam int CODE_W = 12;
  localparam int VAL_W  = CODE_W + 1;
  localparam int EXP_W  = 32;
  localparam int PROD_W = 2 * CODE_W;
  // remainder digits per pipeline stage
  localparam int STEPS  = 4;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_INV    = 3'd4,
    OP_NEG    = 3'd5,
    OP_POW    = 3'd6,
    OP_TBL_WR = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    CFG_ORDER     = 2'd0,
    CFG_MINUS_ONE = 2'd1,
    CFG_CHAR_TWO  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_ZECH   = 2'd1,
    KIND_POW    = 2'd2
  } kind_e;

  typedef struct packed {
    op_e                      req_type;
    logic [CODE_W-1:0]        operand_a;
    logic [CODE_W-1:0]        operand_b;
    logic signed [EXP_W-1:0]  exponent;
    logic [CODE_W-1:0]        table_index;
    logic [VAL_W-1:0]         table_value;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] result;
    logic              error;
  } rsp_t;

  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    logic [EXP_W-1:0]  mag;
    logic              a_nz;
    logic              b_nz;
    logic              neg;
    logic [CODE_W-1:0] tbl_idx;
    logic [VAL_W-1:0]  tbl_val;
  } s0_t;

  typedef struct packed {
    op_e               op;
    logic              a_nz;
    logic              b_nz;
    logic              neg;
    logic [CODE_W-1:0] tbl_idx;
    logic [VAL_W-1:0]  tbl_val;
  } side1_t;

  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    logic [CODE_W-1:0] m1;
    logic [CODE_W-1:0] emod;
    logic [CODE_W-1:0] tbl_idx;
    logic [VAL_W-1:0]  tbl_val;
  } s1_t;

  typedef struct packed {
    op_e               op;
    kind_e             kind;
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] bb;
    logic [CODE_W-1:0] m1;
    logic [CODE_W-1:0] res;
    logic              err;
    logic [PROD_W-1:0] prod;
    logic [CODE_W-1:0] tbl_idx;
    logic [VAL_W-1:0]  tbl_val;
  } s2_t;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] res;
    logic              err;
    logic [CODE_W-1:0] base;
    logic [PROD_W-1:0] prod;
  } s3_t;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] res;
    logic              err;
    logic [CODE_W-1:0] base;
  } side4_t;

endpackage

// File: rtl/gf_zech_log_alu.sv
// throughput: one transaction per cycle while the output is not stalled, set by the pipelined remainder units
//   (8 stages for operand and exponent reduction, 6 for the product/table value)
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset clears valid bits and config (order 1, minus one code 1, char two 1);
// the zech table is not cleared and must be written before it is read
module gf_zech_log_alu import gzla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  cfg_idx_e          cfg_idx_i,
  input  logic [CODE_W-1:0] cfg_data_i
);

  localparam int RED1_STG = (EXP_W + STEPS - 1) / STEPS;
  localparam int RED2_STG = (PROD_W + STEPS - 1) / STEPS;

  // (s mod q) into 1..q for s in 1..2q
  function automatic logic [CODE_W-1:0] wrap_sum(input logic [CODE_W:0]   s,
                                                 input logic [CODE_W-1:0] q);
    return (s > {1'b0, q}) ? CODE_W'(s - {1'b0, q}) : CODE_W'(s);
  endfunction

  // config registers
  logic [CODE_W-1:0] order_q, m1code_q;
  logic              char_two_q;
  logic [CODE_W-1:0] q1;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q    <= CODE_W'(1);
      m1code_q   <= CODE_W'(1);
      char_two_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        CFG_ORDER:     order_q    <= cfg_data_i;
        CFG_MINUS_ONE: m1code_q   <= cfg_data_i;
        CFG_CHAR_TWO:  char_two_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // order register of zero acts as one
  assign q1 = (order_q == '0) ? CODE_W'(1) : order_q;

  // global advance: only a waiting, stalled result holds the pipe
  logic en;
  logic vo_q;
  assign en          = !(vo_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vo_q;

  // ---------------------------------------------------------------
  // input register: exponent magnitude and zero flags
  // ---------------------------------------------------------------
  logic v0_q;
  s0_t  s0_q, s0_d;

  always_comb begin
    s0_d.op      = in_req_i.req_type;
    s0_d.a       = in_req_i.operand_a;
    s0_d.b       = in_req_i.operand_b;
    s0_d.neg     = in_req_i.exponent[EXP_W-1];
    s0_d.mag     = s0_d.neg ? (~in_req_i.exponent + EXP_W'(1)) : in_req_i.exponent;
    s0_d.a_nz    = in_req_i.operand_a != '0;
    s0_d.b_nz    = in_req_i.operand_b != '0;
    s0_d.tbl_idx = in_req_i.table_index;
    s0_d.tbl_val = in_req_i.table_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) s0_q <= s0_d;
  end

  // ---------------------------------------------------------------
  // first reduction: operands, minus one code and |exponent| mod q1
  // ---------------------------------------------------------------
  logic [CODE_W-1:0] ra, rb, rm, re;

  gzla_rem_pipe #(.IN_W(EXP_W)) u_red_a (
    .clk_i, .en_i(en), .q1_i(q1), .x_i(EXP_W'(s0_q.a)), .rem_o(ra));
  gzla_rem_pipe #(.IN_W(EXP_W)) u_red_b (
    .clk_i, .en_i(en), .q1_i(q1), .x_i(EXP_W'(s0_q.b)), .rem_o(rb));
  gzla_rem_pipe #(.IN_W(EXP_W)) u_red_m (
    .clk_i, .en_i(en), .q1_i(q1), .x_i(EXP_W'(m1code_q)), .rem_o(rm));
  gzla_rem_pipe #(.IN_W(EXP_W)) u_red_e (
    .clk_i, .en_i(en), .q1_i(q1), .x_i(s0_q.mag), .rem_o(re));

  side1_t side1_in, side1_out;
  logic   v1_out;

  always_comb begin
    side1_in.op      = s0_q.op;
    side1_in.a_nz    = s0_q.a_nz;
    side1_in.b_nz    = s0_q.b_nz;
    side1_in.neg     = s0_q.neg;
    side1_in.tbl_idx = s0_q.tbl_idx;
    side1_in.tbl_val = s0_q.tbl_val;
  end

  gzla_delay #(.WIDTH($bits(side1_t) + 1), .DEPTH(RED1_STG)) u_dly1 (
    .clk_i, .rst_ni, .en_i(en),
    .d_i({v0_q, side1_in}),
    .q_o({v1_out, side1_out})
  );

  // ---------------------------------------------------------------
  // stage 1: map remainders back into code range
  // ---------------------------------------------------------------
  logic v1_q;
  s1_t  s1_q, s1_d;

  always_comb begin
    s1_d.op      = side1_out.op;
    s1_d.a       = side1_out.a_nz ? ((ra == '0) ? q1 : ra) : '0;
    s1_d.b       = side1_out.b_nz ? ((rb == '0) ? q1 : rb) : '0;
    s1_d.m1      = (rm == '0) ? q1 : rm;
    // negative exponent: -e mod q1
    s1_d.emod    = (side1_out.neg && re != '0) ? (q1 - re) : re;
    s1_d.tbl_idx = side1_out.tbl_idx;
    s1_d.tbl_val = side1_out.tbl_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v1_out;
  end

  always_ff @(posedge clk_i) begin
    if (en) s1_q <= s1_d;
  end

  // ---------------------------------------------------------------
  // stage 2: exponent arithmetic, add/sub shortcuts, power product
  // ---------------------------------------------------------------
  logic v2_q;
  s2_t  s2_q, s2_d;
  logic [CODE_W-1:0] sum_ab, b_m1, a_m1;

  assign sum_ab = wrap_sum({1'b0, s1_q.a} + {1'b0, s1_q.b}, q1);
  assign b_m1   = wrap_sum({1'b0, s1_q.b} + {1'b0, s1_q.m1}, q1);
  assign a_m1   = wrap_sum({1'b0, s1_q.a} + {1'b0, s1_q.m1}, q1);

  always_comb begin
    s2_d.op      = s1_q.op;
    s2_d.kind    = KIND_DIRECT;
    s2_d.a       = s1_q.a;
    s2_d.bb      = s1_q.b;
    s2_d.m1      = s1_q.m1;
    s2_d.res     = '0;
    s2_d.err     = 1'b0;
    s2_d.prod    = PROD_W'(s1_q.a) * PROD_W'(s1_q.emod);
    s2_d.tbl_idx = s1_q.tbl_idx;
    s2_d.tbl_val = s1_q.tbl_val;
    unique case (s1_q.op)
      OP_ADD: begin
        if (s1_q.b == '0)      s2_d.res  = s1_q.a;
        else if (s1_q.a == '0) s2_d.res  = s1_q.b;
        else                   s2_d.kind = KIND_ZECH;
      end
      OP_SUB: begin
        // a - b is a + (minus one * b)
        if (s1_q.b == '0)           s2_d.res = s1_q.a;
        else if (s1_q.a == s1_q.b)  s2_d.res = '0;
        else if (s1_q.a == '0)      s2_d.res = b_m1;
        else begin
          s2_d.kind = KIND_ZECH;
          s2_d.bb   = b_m1;
        end
      end
      OP_MUL: s2_d.res = (s1_q.a == '0 || s1_q.b == '0) ? '0 : sum_ab;
      OP_DIV: begin
        if (s1_q.b == '0) s2_d.err = 1'b1;
        else if (s1_q.a != '0) begin
          s2_d.res = (s1_q.a > s1_q.b) ? (s1_q.a - s1_q.b)
                                       : CODE_W'({1'b0, s1_q.a} + {1'b0, q1} - {1'b0, s1_q.b});
        end
      end
      OP_INV: begin
        if (s1_q.a == '0)      s2_d.err = 1'b1;
        else if (s1_q.a == q1) s2_d.res = q1;
        else                   s2_d.res = q1 - s1_q.a;
      end
      OP_NEG: s2_d.res = (s1_q.a == '0) ? '0 : a_m1;
      OP_POW: begin
        if (s1_q.a != '0) s2_d.kind = KIND_POW;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) s2_q <= s2_d;
  end

  // ---------------------------------------------------------------
  // stage 3: zech index, table write and table read
  // ---------------------------------------------------------------
  logic              v3_q;
  s3_t               s3_q, s3_d;
  logic [CODE_W-1:0] raddr;
  logic [VAL_W-1:0]  zech_rd;
  logic              tbl_we;

  always_comb begin
    s3_d.kind = s2_q.kind;
    s3_d.res  = s2_q.res;
    s3_d.err  = s2_q.err;
    s3_d.base = s2_q.a;
    s3_d.prod = s2_q.prod;
    raddr     = '0;
    if (s2_q.kind == KIND_ZECH) begin
      if (s2_q.a == s2_q.bb) begin
        // x + x: zero in characteristic two, else x * (1 + 1)
        if (char_two_q) begin
          s3_d.kind = KIND_DIRECT;
          s3_d.res  = '0;
        end else begin
          raddr = q1;
        end
      end else begin
        if (s2_q.a > s2_q.bb) begin
          raddr     = s2_q.a - s2_q.bb;
          s3_d.base = s2_q.bb;
        end else begin
          raddr     = s2_q.bb - s2_q.a;
        end
        // alpha^n + 1 is zero when alpha^n is minus one
        if (raddr == s2_q.m1) begin
          s3_d.kind = KIND_DIRECT;
          s3_d.res  = '0;
        end
      end
    end
  end

  assign tbl_we = en && v2_q && (s2_q.op == OP_TBL_WR);

  gzla_zech_ram u_zech (
    .clk_i,
    .en_i   (en),
    .we_i   (tbl_we),
    .waddr_i(s2_q.tbl_idx),
    .wdata_i(s2_q.tbl_val),
    .raddr_i(raddr),
    .rdata_o(zech_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) s3_q <= s3_d;
  end

  // ---------------------------------------------------------------
  // second reduction: power product or table value mod q1
  // ---------------------------------------------------------------
  logic [PROD_W-1:0] red2_x;
  logic [CODE_W-1:0] r2;
  side4_t            side4_in, side4_out;
  logic              v4_out;

  assign red2_x = (s3_q.kind == KIND_POW) ? s3_q.prod : PROD_W'(zech_rd);

  gzla_rem_pipe #(.IN_W(PROD_W)) u_red_p (
    .clk_i, .en_i(en), .q1_i(q1), .x_i(red2_x), .rem_o(r2));

  always_comb begin
    side4_in.kind = s3_q.kind;
    side4_in.res  = s3_q.res;
    side4_in.err  = s3_q.err;
    side4_in.base = s3_q.base;
  end

  gzla_delay #(.WIDTH($bits(side4_t) + 1), .DEPTH(RED2_STG)) u_dly2 (
    .clk_i, .rst_ni, .en_i(en),
    .d_i({v3_q, side4_in}),
    .q_o({v4_out, side4_out})
  );

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  rsp_t rsp_d, rsp_q;

  always_comb begin
    rsp_d.result = side4_out.res;
    rsp_d.error  = side4_out.err;
    unique case (side4_out.kind)
      KIND_DIRECT: ;
      KIND_POW:    rsp_d.result = (r2 == '0) ? q1 : r2;
      KIND_ZECH:   rsp_d.result = wrap_sum({1'b0, side4_out.base} + {1'b0, r2}, q1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en) vo_q <= v4_out;
  end

  always_ff @(posedge clk_i) begin
    if (en) rsp_q <= rsp_d;
  end

  assign out_rsp_o = rsp_q;

endmodule

// File: rtl/gzla_delay.sv
module gzla_delay import gzla_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] sh_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) sh_q[i] <= '0;
    end else if (en_i) begin
      sh_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) sh_q[i] <= sh_q[i-1];
    end
  end

  assign q_o = sh_q[DEPTH-1];

endmodule

// File: rtl/gzla_rem_pipe.sv
module gzla_rem_pipe import gzla_pkg::*; #(
  parameter int IN_W = 32
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CODE_W-1:0] q1_i,
  input  logic [IN_W-1:0]   x_i,
  output logic [CODE_W-1:0] rem_o
);

  localparam int NSTG  = (IN_W + STEPS - 1) / STEPS;
  localparam int PAD_W = NSTG * STEPS;

  // restoring remainder, msb first, STEPS digits per stage
  function automatic logic [CODE_W-1:0] rem_steps(input logic [CODE_W-1:0] r_in,
                                                  input logic [STEPS-1:0]  bits,
                                                  input logic [CODE_W-1:0] q1);
    logic [CODE_W:0]   t;
    logic [CODE_W-1:0] r;
    r = r_in;
    for (int j = STEPS - 1; j >= 0; j--) begin
      t = {r, bits[j]};
      if (t >= {1'b0, q1}) t = t - {1'b0, q1};
      r = t[CODE_W-1:0];
    end
    return r;
  endfunction

  logic [PAD_W-1:0]  x_pad;
  logic [PAD_W-1:0]  x_q [NSTG-1];
  logic [CODE_W-1:0] r_q [NSTG];

  assign x_pad = PAD_W'(x_i);

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[0] <= rem_steps('0, x_pad[PAD_W-1 -: STEPS], q1_i);
          x_q[0] <= x_pad;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[s] <= rem_steps(r_q[s-1], x_q[s-1][PAD_W-1-s*STEPS -: STEPS], q1_i);
        end
      end
      if (s < NSTG - 1) begin : g_carry
        always_ff @(posedge clk_i) begin
          if (en_i) x_q[s] <= x_q[s-1];
        end
      end
    end
  end

  assign rem_o = r_q[NSTG-1];

endmodule

// File: rtl/gzla_zech_ram.sv
module gzla_zech_ram import gzla_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [CODE_W-1:0] waddr_i,
  input  logic [VAL_W-1:0]  wdata_i,
  input  logic [CODE_W-1:0] raddr_i,
  output logic [VAL_W-1:0]  rdata_o
);

  logic [VAL_W-1:0] mem [2**CODE_W];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gzla_port_checker.sv
`include "gf_zech_log_alu_macros.svh"

module gzla_port_checker import gzla_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  `GZLA_ASSERT(a_out_valid_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `GZLA_ASSERT_HOLD(a_out_data_hold, out_valid_o && out_stall_i, out_rsp_o, "stalled result changed")
  `GZLA_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a stalled result")
  `GZLA_ASSERT(a_err_zero, out_valid_o && out_rsp_o.error |-> out_rsp_o.result == '0, "error transaction with nonzero result")

endmodule

bind gf_zech_log_alu gzla_port_checker u_port_checker (.*);
